[src/mhbh_pkg.sv]
// package for the multiplicative hash bucket histogram
// types and constants shared by the multiplier, top level and testbench
// depends on nothing
`default_nettype none

package mhbh_pkg;

  // golden ratio fraction 0.61803 as unsigned q0.32
  localparam logic [31:0] HASH_MULT = 32'd2654418638;

  // field widths fixed by the interface
  localparam int CNT_W   = 16;
  localparam int OUT_IDX_W = 6;
  localparam int TS_W    = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [TS_W-1:0]  TS_RESET  = 7'd64;

  // register index, taken from paddr[2]
  localparam logic REG_TABLE_SIZE = 1'b0;

  // multiplier controls
  typedef struct packed {
    logic        load;
    logic [31:0] a;
    logic [31:0] b;
  } mul_ctl_t;

endpackage

`default_nettype wire

[src/mhbh_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no package dependency
`default_nettype none

module mhbh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/mhbh_mul.sv]
// shared 32x32 multiplier with registered 64-bit product
// depends on mhbh_pkg for the control struct
`default_nettype none

module mhbh_mul (
  input  wire logic              clk,
  input  wire mhbh_pkg::mul_ctl_t ctl,
  output logic [63:0]            prod
);

  // product register, holds while not loaded
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= 64'(ctl.a) * 64'(ctl.b);
    end
  end

endmodule

`default_nettype wire

[src/multiplicative_hash_bucket_histogram.sv]
// top level: sequencer, apb register, valid bits, counter ram and shared multiplier
// depends on mhbh_pkg, mhbh_ram and mhbh_mul
//
// channel | signals                                 | direction
// --------+-----------------------------------------+----------
// input   | in_valid, in_ready, key, last_key       | in
// output  | out_valid, out_ready, bucket_index,     | out
//         | bucket_count, last_count                |
// config  | apb: psel, penable, pwrite, paddr, ...  | in/out
//
// an item runs the shared multiplier twice (key * fraction, then fraction *
// table size), then one counter ram read and one write. a last item then
// reads the count of each bucket in use from the ram and shows it, waiting
// whenever the output side stalls.
// reset clears the valid bits of all counters at once; there is no clearing pass.
// the final count may wait in the output register while the next item is taken.
`default_nettype none

module multiplicative_hash_bucket_histogram #(
  parameter int BUCKETS  = 64,
  parameter int KEY_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // apb configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mhbh_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [mhbh_pkg::PDATA_W-1:0]      pwdata,
  output logic      [mhbh_pkg::PDATA_W-1:0]      prdata,
  output logic                                   pready,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [KEY_BITS-1:0]               key,
  input  wire logic                              last_key,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [mhbh_pkg::OUT_IDX_W-1:0]    bucket_index,
  output logic      [mhbh_pkg::CNT_W-1:0]        bucket_count,
  output logic                                   last_count
);

  localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [mhbh_pkg::TS_W-1:0] MAX_SIZE = mhbh_pkg::TS_W'(BUCKETS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_BUCKET,
    S_UPDATE,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  state_t                      state;
  logic [mhbh_pkg::TS_W-1:0]   table_size;
  logic [mhbh_pkg::TS_W-1:0]   size_q;
  logic [mhbh_pkg::TS_W-1:0]   size_used;
  logic                        last_q;
  logic [IDX_W-1:0]            idx;
  logic [BUCKETS-1:0]          vbits;
  logic                        cfg_wr;

  mhbh_pkg::mul_ctl_t          mul_ctl;
  logic [63:0]                 prod;
  logic [IDX_W-1:0]            bucket;

  logic                        ram_we;
  logic [mhbh_pkg::CNT_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [IDX_W-1:0]            ram_raddr;
  logic [mhbh_pkg::CNT_W-1:0]  ram_rdata;
  logic [mhbh_pkg::CNT_W-1:0]  cur_count;
  logic [mhbh_pkg::CNT_W-1:0]  dump_count;
  logic                        out_free;

  // apb register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == mhbh_pkg::REG_TABLE_SIZE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == mhbh_pkg::REG_TABLE_SIZE) begin
      prdata = mhbh_pkg::PDATA_W'(table_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= mhbh_pkg::TS_RESET;
    end else if (cfg_wr) begin
      table_size <= pwdata[mhbh_pkg::TS_W-1:0];
    end
  end

  // clamp table size to 1..BUCKETS
  always_comb begin
    priority if (table_size == '0) begin
      size_used = mhbh_pkg::TS_W'(1);
    end else if (table_size > MAX_SIZE) begin
      size_used = MAX_SIZE;
    end else begin
      size_used = table_size;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_ctl.load = 1'b0;
    mul_ctl.a    = 32'(key);
    mul_ctl.b    = mhbh_pkg::HASH_MULT;
    if (state == S_IDLE) begin
      mul_ctl.load = in_valid;
    end else if (state == S_HASH) begin
      mul_ctl.load = 1'b1;
      mul_ctl.a    = prod[31:0];
      mul_ctl.b    = 32'(size_q);
    end
  end

  mhbh_mul u_mul (
    .clk  (clk),
    .ctl  (mul_ctl),
    .prod (prod)
  );

  // floor(frac * size / 2^32), always below size
  assign bucket = prod[32 +: IDX_W];

  // counter ram access
  assign cur_count  = vbits[bucket] ? ram_rdata : '0;
  assign dump_count = vbits[idx] ? ram_rdata : '0;
  assign ram_we     = (state == S_UPDATE);
  assign ram_wdata  = (cur_count == mhbh_pkg::COUNT_MAX) ? cur_count
                                                        : cur_count + 1'b1;
  assign ram_re     = (state == S_BUCKET) || (state == S_DUMP_RD);
  assign ram_raddr  = (state == S_DUMP_RD) ? idx : bucket;

  mhbh_ram #(
    .WIDTH (mhbh_pkg::CNT_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bucket),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // sequencer with valid bits and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vbits     <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      last_q    <= 1'b0;
      size_q    <= mhbh_pkg::TS_RESET;
    end else begin
      // result taken, unless a new one is loaded in its place
      if (out_valid && out_ready && state != S_DUMP_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_q <= last_key;
            size_q <= size_used;
            state  <= S_HASH;
          end
        end
        S_HASH: begin
          state <= S_BUCKET;
        end
        S_BUCKET: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          vbits[bucket] <= 1'b1;
          idx           <= '0;
          state         <= last_q ? S_DUMP_RD : S_IDLE;
        end
        S_DUMP_RD: begin
          state <= S_DUMP_OUT;
        end
        S_DUMP_OUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            bucket_index <= mhbh_pkg::OUT_IDX_W'(idx);
            bucket_count <= dump_count;
            last_count   <= (mhbh_pkg::TS_W'(idx) + 1'b1 == size_q);
            if (mhbh_pkg::TS_W'(idx) + 1'b1 == size_q) begin
              vbits <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DUMP_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/mhbh_checker.sv]
// port-level checker for the histogram top level, with its bind statement
// depends on multiplicative_hash_bucket_histogram ports only
`default_nettype none

module mhbh_checker #(
  parameter int BUCKETS = 64
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] bucket_index,
  input wire logic [15:0] bucket_count,
  input wire logic       last_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bucket_count) &&
                                $stable(bucket_index) && $stable(last_count))
    else $error("stalled result changed");

  // an accepted item keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous item still in work");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

  // reported bucket lies inside the table
  a_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(bucket_index) < BUCKETS))
    else $error("bucket index out of range");

endmodule

bind multiplicative_hash_bucket_histogram mhbh_checker #(.BUCKETS(BUCKETS)) u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .bucket_index (bucket_index),
  .bucket_count (bucket_count),
  .last_count   (last_count)
);

`default_nettype wire

[test/tb_multiplicative_hash_bucket_histogram.sv]
`timescale 1ns / 1ps
// testbench for the multiplicative hash bucket histogram: keys in, bucket counts out
// scoreboard against a behavioral model of the hash and counters; apb table size writes
// depends on mhbh_pkg and multiplicative_hash_bucket_histogram

module tb_multiplicative_hash_bucket_histogram;

  localparam int BUCKETS     = 64;
  localparam int KEY_BITS    = 16;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE      = 20;
  localparam int IDLE_PCT    = 26;
  localparam logic [mhbh_pkg::PADDR_W-1:0] ADDR_TABLE_SIZE =
    {mhbh_pkg::REG_TABLE_SIZE, 2'b00};

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                last;
  } key_item_t;

  typedef struct packed {
    logic [mhbh_pkg::OUT_IDX_W-1:0] idx;
    logic [mhbh_pkg::CNT_W-1:0]     count;
    logic                           last;
  } bucket_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [mhbh_pkg::PADDR_W-1:0] paddr   = '0;
  logic [mhbh_pkg::PDATA_W-1:0] pwdata  = '0;
  logic [mhbh_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KEY_BITS-1:0] key      = '0;
  logic                last_key = 1'b0;

  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [mhbh_pkg::OUT_IDX_W-1:0] bucket_index;
  logic [mhbh_pkg::CNT_W-1:0]     bucket_count;
  logic                           last_count;

  // scoreboard state
  key_item_t      key_queue[$];
  bucket_report_t report_queue[$];
  logic [mhbh_pkg::CNT_W-1:0] model_counts[BUCKETS];
  logic [mhbh_pkg::TS_W-1:0]  model_table_size;
  logic             calm = 1'b0;
  int unsigned keys_sent = 0;
  int unsigned keys_taken = 0;
  int unsigned counts_checked = 0;
  int unsigned sizes_written = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  multiplicative_hash_bucket_histogram #(
    .BUCKETS (BUCKETS),
    .KEY_BITS(KEY_BITS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .key         (key),
    .last_key    (last_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bucket_index(bucket_index),
    .bucket_count(bucket_count),
    .last_count  (last_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // zero and oversize table sizes fold into 1..BUCKETS
  function automatic int unsigned buckets_in_use(logic [mhbh_pkg::TS_W-1:0] ts);
    if (ts == 0) return 1;
    if (ts > BUCKETS) return BUCKETS;
    return ts;
  endfunction

  // floor(frac(key * 0.61803) * size), fraction in q0.32
  function automatic int unsigned hash_to_bucket(logic [KEY_BITS-1:0] k, int unsigned size);
    logic [31:0] frac;
    logic [63:0] prod;
    frac = 32'(k) * mhbh_pkg::HASH_MULT;
    prod = 64'(frac) * 64'(size);
    return prod[63:32];
  endfunction

  // count one key; on the last key queue every bucket in use and clear all
  task automatic count_key(input logic [KEY_BITS-1:0] k, input logic lst);
    int unsigned size;
    int unsigned b;
    bucket_report_t r;
    size = buckets_in_use(model_table_size);
    b = hash_to_bucket(k, size);
    if (model_counts[b] != mhbh_pkg::COUNT_MAX) model_counts[b] = model_counts[b] + 1'b1;
    if (lst) begin
      for (int unsigned i = 0; i < size; i++) begin
        r.idx = mhbh_pkg::OUT_IDX_W'(i);
        r.count = model_counts[i];
        r.last = (i + 1 == size);
        report_queue.push_back(r);
      end
      for (int i = 0; i < BUCKETS; i++) model_counts[i] = '0;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        count_key(key, last_key);
        keys_taken++;
      end
      if (!in_valid || in_ready) begin
        if (key_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          key      <= key_queue[0].key;
          last_key <= key_queue[0].last;
          key_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    bucket_report_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (report_queue.size() == 0) begin
          $error("count for bucket %0d with nothing expected", bucket_index);
          errors++;
        end else begin
          exp_r = report_queue.pop_front();
          counts_checked++;
          if (bucket_index !== exp_r.idx) begin
            $error("bucket_index expected %0d got %0d", exp_r.idx, bucket_index);
            errors++;
          end
          if (bucket_count !== exp_r.count) begin
            $error("bucket_count expected %0d got %0d", exp_r.count, bucket_count);
            errors++;
          end
          if (last_count !== exp_r.last) begin
            $error("last_count expected %0d got %0d", exp_r.last, last_count);
            errors++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d counts outstanding", cycles, report_queue.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_key(input logic [KEY_BITS-1:0] k, input logic lst);
    key_item_t it;
    it.key = k;
    it.last = lst;
    key_queue.push_back(it);
    keys_sent++;
  endtask

  // sender holds off until every key is taken and every count has come back
  task automatic drain();
    while (keys_taken != keys_sent || report_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // apb write of the table size, upper data bits random
  task automatic write_table_size(input logic [mhbh_pkg::TS_W-1:0] ts);
    logic [mhbh_pkg::PDATA_W-1:0] wd;
    wd = mhbh_pkg::PDATA_W'($urandom());
    wd[mhbh_pkg::TS_W-1:0] = ts;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TABLE_SIZE;
    pwdata  <= wd;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_table_size = ts;
    sizes_written++;
  endtask

  function automatic logic [KEY_BITS-1:0] random_key();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
    endcase
  endfunction

  initial begin
    int unsigned n;
    logic [mhbh_pkg::TS_W-1:0] ts;
    model_table_size = mhbh_pkg::TS_RESET;
    for (int i = 0; i < BUCKETS; i++) model_counts[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset table size, key extremes and alternating bits
    push_key('0, 1'b0);
    push_key('1, 1'b0);
    push_key(16'h0001, 1'b0);
    push_key(16'h8000, 1'b0);
    push_key(16'h5555, 1'b0);
    push_key(16'hAAAA, 1'b1);
    drain();

    // single bucket, then zero treated as one
    write_table_size(7'd1);
    push_key(16'h1234, 1'b0);
    push_key('1, 1'b1);
    drain();
    write_table_size(7'd0);
    push_key(16'h00FF, 1'b0);
    push_key(16'hFF00, 1'b1);
    drain();

    // oversize table sizes clamp to the full table
    write_table_size(7'd127);
    push_key(16'h7FFF, 1'b0);
    push_key(16'h0002, 1'b1);
    drain();
    write_table_size(7'd65);
    push_key(16'hC0DE, 1'b1);
    drain();

    // size shrinks mid set: unreported buckets still cleared
    write_table_size(7'd64);
    push_key('1, 1'b0);
    push_key(16'hFFFE, 1'b0);
    push_key(16'h0003, 1'b0);
    drain();
    write_table_size(7'd4);
    push_key(16'h0004, 1'b1);
    drain();
    write_table_size(7'd64);
    push_key(16'h0005, 1'b1);
    drain();

    // long run into a single bucket, no idling
    calm = 1'b1;
    write_table_size(7'd1);
    for (int i = 0; i < 30; i++) push_key(random_key(), 1'b0);
    push_key(random_key(), 1'b1);
    drain();
    calm = 1'b0;

    // random phases, mostly small tables
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: ts = 7'd0;
        1: ts = 7'd127;
        2: ts = 7'd64;
        default: ts = ($urandom_range(4) == 0) ?
                      mhbh_pkg::TS_W'($urandom_range(65, 127)) :
                      mhbh_pkg::TS_W'($urandom_range(1, 16));
      endcase
      calm = (p == 3);
      write_table_size(ts);
      n = $urandom_range(12, 20);
      for (int i = 0; i < n; i++) push_key(random_key(), (i == n - 1) || ($urandom_range(4) == 0));
      drain();
    end
    calm = 1'b0;

    $display("sent %0d keys under %0d table size writes", keys_sent, sizes_written);
    $display("checked %0d bucket counts, %0d mismatches", counts_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
